FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Check a boolean at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

// Check that an antecedent is followed in the next cycle by a consequent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, clk, rst_n, expr)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: design/fsgs_pkg.sv
// ----------------------------------------------------------------------------
// fsgs_pkg
// Constants, control-word types and microprogram for the grain step core.
// ----------------------------------------------------------------------------
package fsgs_pkg;

    // Grid geometry
    localparam int GRID_MAX = 32;
    localparam int COORD_W  = $clog2(GRID_MAX);
    localparam int SIZE_W   = 6;
    localparam int ROW_W    = GRID_MAX;
    localparam int ROW_AW   = 2 * COORD_W;
    localparam int ROWS     = GRID_MAX * GRID_MAX;
    localparam int CNT_W    = 16;
    localparam int K_W      = 4;
    localparam int PC_W     = 5;

    typedef logic [PC_W-1:0] t_pc;

    // Commands
    localparam logic [1:0] CMD_ADD   = 2'd0;
    localparam logic [1:0] CMD_MOVE  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;
    localparam logic [1:0] CMD_NONE  = 2'd3;

    // Result status codes
    localparam logic [2:0] ST_ADDED    = 3'd0;
    localparam logic [2:0] ST_RANGE    = 3'd1;
    localparam logic [2:0] ST_OCCUPIED = 3'd2;
    localparam logic [2:0] ST_MOVED    = 3'd3;
    localparam logic [2:0] ST_SETTLED  = 3'd4;
    localparam logic [2:0] ST_CLEARED  = 3'd5;

    // Last neighbour probe: straight down is probe 0, the diagonals 1 to 8
    localparam logic [K_W-1:0] K_LAST = K_W'(8);

    // Microprogram step addresses
    localparam t_pc PC_IDLE      = t_pc'(0);
    localparam t_pc PC_CHK_BAD   = t_pc'(1);
    localparam t_pc PC_CHK_CLR   = t_pc'(2);
    localparam t_pc PC_RD_SRC    = t_pc'(3);
    localparam t_pc PC_SRC_DATA  = t_pc'(4);
    localparam t_pc PC_MV_EMPTY  = t_pc'(5);
    localparam t_pc PC_MV_FLOOR  = t_pc'(6);
    localparam t_pc PC_MV_RD0    = t_pc'(7);
    localparam t_pc PC_MV_TEST   = t_pc'(8);
    localparam t_pc PC_MV_NEXT   = t_pc'(9);
    localparam t_pc PC_MV_SKIP   = t_pc'(10);
    localparam t_pc PC_MV_RD     = t_pc'(11);
    localparam t_pc PC_MV_SET    = t_pc'(12);
    localparam t_pc PC_MV_CLR    = t_pc'(13);
    localparam t_pc PC_E_MOVED   = t_pc'(14);
    localparam t_pc PC_ADD_TEST  = t_pc'(15);
    localparam t_pc PC_ADD_SET   = t_pc'(16);
    localparam t_pc PC_E_ADDED   = t_pc'(17);
    localparam t_pc PC_E_OCC     = t_pc'(18);
    localparam t_pc PC_E_RANGE   = t_pc'(19);
    localparam t_pc PC_E_SETTLED = t_pc'(20);
    localparam t_pc PC_CLR_SWEEP = t_pc'(21);
    localparam t_pc PC_E_CLEARED = t_pc'(22);
    localparam t_pc PC_RST_SWEEP = t_pc'(23);
    localparam t_pc PC_RST_DONE  = t_pc'(24);

    typedef enum logic [1:0] {
        J_SEQ,
        J_ALW,
        J_IF
    } t_jump;

    typedef enum logic [3:0] {
        C_BAD,
        C_CLEAR,
        C_ADD,
        C_SRC_EMPTY,
        C_SRC_SET,
        C_FLOOR,
        C_CAND_FREE,
        C_K_LAST,
        C_CAND_OUT,
        C_SWEEP_MORE
    } t_cond;

    typedef enum logic {
        A_SRC,
        A_CAND
    } t_asel;

    typedef enum logic [1:0] {
        W_CAND_SET,
        W_SRC_SET,
        W_SRC_CLR,
        W_ZERO
    } t_wsel;

    typedef struct packed {
        t_jump      jmp;
        t_cond      cond;
        t_pc        target;
        logic       rd;
        t_asel      asel;
        logic       wr;
        t_wsel      wsel;
        logic       src_cap;
        logic       k_clr;
        logic       k_inc;
        logic       cnt_inc;
        logic       cnt_clr;
        logic       pos_upd;
        logic       pos_clr;
        logic       sweep;
        logic       wait_in;
        logic       emit;
        logic [2:0] status;
    } t_uword;

    // Probe offsets in x, as 6-bit two's complement
    function automatic logic [SIZE_W-1:0] cand_dx(input logic [K_W-1:0] k);
        logic [SIZE_W-1:0] d;
        unique case (k)
            K_W'(1), K_W'(2), K_W'(3): d = SIZE_W'(1);
            K_W'(6), K_W'(7), K_W'(8): d = '1;
            default:                   d = '0;
        endcase
        return d;
    endfunction

    // Probe offsets in z, as 6-bit two's complement
    function automatic logic [SIZE_W-1:0] cand_dz(input logic [K_W-1:0] k);
        logic [SIZE_W-1:0] d;
        unique case (k)
            K_W'(1), K_W'(4), K_W'(6): d = SIZE_W'(1);
            K_W'(3), K_W'(5), K_W'(8): d = '1;
            default:                   d = '0;
        endcase
        return d;
    endfunction

    // Emit a result and return to idle
    function automatic t_uword uw_emit(input logic [2:0] st);
        t_uword w;
        w        = '0;
        w.jmp    = J_ALW;
        w.target = PC_IDLE;
        w.emit   = 1'b1;
        w.status = st;
        return w;
    endfunction

    // Conditional jump with no side effects
    function automatic t_uword uw_jif(input t_cond c, input t_pc tgt);
        t_uword w;
        w        = '0;
        w.jmp    = J_IF;
        w.cond   = c;
        w.target = tgt;
        return w;
    endfunction

    // Microprogram ROM
    function automatic t_uword ucode(input t_pc pc);
        t_uword w;
        w = '0;
        unique case (pc)
            PC_IDLE: begin
                w.wait_in = 1'b1;
            end
            PC_CHK_BAD:   w = uw_jif(C_BAD, PC_E_RANGE);
            PC_CHK_CLR:   w = uw_jif(C_CLEAR, PC_CLR_SWEEP);
            PC_RD_SRC: begin
                w.rd    = 1'b1;
                w.asel  = A_SRC;
                w.k_clr = 1'b1;
            end
            PC_SRC_DATA: begin
                w         = uw_jif(C_ADD, PC_ADD_TEST);
                w.src_cap = 1'b1;
            end
            PC_MV_EMPTY:  w = uw_jif(C_SRC_EMPTY, PC_E_RANGE);
            PC_MV_FLOOR:  w = uw_jif(C_FLOOR, PC_E_SETTLED);
            PC_MV_RD0: begin
                w.rd   = 1'b1;
                w.asel = A_CAND;
            end
            PC_MV_TEST:   w = uw_jif(C_CAND_FREE, PC_MV_SET);
            PC_MV_NEXT: begin
                w       = uw_jif(C_K_LAST, PC_E_SETTLED);
                w.k_inc = 1'b1;
            end
            PC_MV_SKIP:   w = uw_jif(C_CAND_OUT, PC_MV_NEXT);
            PC_MV_RD: begin
                w.jmp    = J_ALW;
                w.target = PC_MV_TEST;
                w.rd     = 1'b1;
                w.asel   = A_CAND;
            end
            PC_MV_SET: begin
                w.wr   = 1'b1;
                w.wsel = W_CAND_SET;
            end
            PC_MV_CLR: begin
                w.wr      = 1'b1;
                w.wsel    = W_SRC_CLR;
                w.pos_upd = 1'b1;
            end
            PC_E_MOVED:   w = uw_emit(ST_MOVED);
            PC_ADD_TEST:  w = uw_jif(C_SRC_SET, PC_E_OCC);
            PC_ADD_SET: begin
                w.wr      = 1'b1;
                w.wsel    = W_SRC_SET;
                w.cnt_inc = 1'b1;
            end
            PC_E_ADDED:   w = uw_emit(ST_ADDED);
            PC_E_OCC:     w = uw_emit(ST_OCCUPIED);
            PC_E_RANGE:   w = uw_emit(ST_RANGE);
            PC_E_SETTLED: w = uw_emit(ST_SETTLED);
            PC_CLR_SWEEP: begin
                w         = uw_jif(C_SWEEP_MORE, PC_CLR_SWEEP);
                w.wr      = 1'b1;
                w.wsel    = W_ZERO;
                w.sweep   = 1'b1;
                w.cnt_clr = 1'b1;
                w.pos_clr = 1'b1;
            end
            PC_E_CLEARED: w = uw_emit(ST_CLEARED);
            PC_RST_SWEEP: begin
                w       = uw_jif(C_SWEEP_MORE, PC_RST_SWEEP);
                w.wr    = 1'b1;
                w.wsel  = W_ZERO;
                w.sweep = 1'b1;
            end
            PC_RST_DONE: begin
                w.jmp    = J_ALW;
                w.target = PC_IDLE;
            end
            default: begin
                w.jmp    = J_ALW;
                w.target = PC_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

FILE: design/falling_sand_grain_step_core.sv
// ----------------------------------------------------------------------------
// falling_sand_grain_step_core
// One step of a 3D falling-sand grid: add, move or clear, one result a beat.
// ----------------------------------------------------------------------------
// A small microcoded sequencer steps each command through one single-port
// occupancy memory of GRID_MAX*GRID_MAX rows, each row one bit per z cell,
// with one read or one write a cycle and registered read data. An add reads
// the source row, tests the cell and, when it is free, sets it. A move reads
// the source row, answers on an empty cell or on the floor, then probes
// straight down and the eight diagonals in turn, reading and testing each
// probe that lies in the grid and skipping the others; it moves into the
// first free cell, or settles when all are taken. An add or move out of
// range, and the unused command, answers with the range status. A
// clear wipes one row a cycle. The sequencer returns to its idle step after
// each result, and only there takes the next beat. After reset the same wipe
// runs before the first beat is taken. Results sit in an output register,
// so the next command is taken while a result still waits; it then runs up
// to its own result and holds there. grid_size applies at once when written
// and is saturated to GRID_MAX.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module falling_sand_grain_step_core
    import fsgs_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    // configuration
    input  logic                i_cfg_we,
    input  logic [SIZE_W-1:0]   i_cfg_wdata,
    // command channel
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [1:0]          i_cmd,
    input  logic [COORD_W-1:0]  i_in_x,
    input  logic [COORD_W-1:0]  i_in_y,
    input  logic [COORD_W-1:0]  i_in_z,
    // result channel
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [2:0]          o_status,
    output logic [COORD_W-1:0]  o_out_x,
    output logic [COORD_W-1:0]  o_out_y,
    output logic [COORD_W-1:0]  o_out_z,
    output logic [CNT_W-1:0]    o_grain_total
);

    // Sequencer and control state
    t_pc                r_pc, n_pc;
    logic [K_W-1:0]     r_k;
    logic [ROW_AW-1:0]  r_sweep;
    logic [CNT_W-1:0]   r_count;
    logic [SIZE_W-1:0]  r_grid_size;
    logic               r_out_valid;

    // Datapath registers
    logic [1:0]         r_cmd;
    logic [COORD_W-1:0] r_x, r_y, r_z;
    logic [ROW_W-1:0]   r_rdata;
    logic [ROW_W-1:0]   r_src_row;
    logic [2:0]         r_status;
    logic [COORD_W-1:0] r_ox, r_oy, r_oz;
    logic [CNT_W-1:0]   r_ototal;

    // Occupancy memory
    logic [ROW_W-1:0]   mem [ROWS];

    t_uword             u;
    logic               in_acc, out_free, go, cond_true;
    logic [SIZE_W-1:0]  size_use;
    logic               in_grid;
    logic [SIZE_W-1:0]  nx, nz;
    logic [COORD_W-1:0] ny;
    logic               cand_out;
    logic [ROW_AW-1:0]  src_row, cand_row, raddr, waddr;
    logic [ROW_W-1:0]   wdata;
    logic [ROW_W-1:0]   bit_z, bit_nz;

    // Decode the current control word
    assign u = ucode(r_pc);

    assign in_acc     = i_in_valid && !o_in_stall;
    assign o_in_stall = !u.wait_in;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign go         = (!u.wait_in || i_in_valid) && (!u.emit || out_free);

    // Range check against the saturated grid size
    assign size_use = (r_grid_size > SIZE_W'(GRID_MAX)) ? SIZE_W'(GRID_MAX) : r_grid_size;
    assign in_grid  = ({1'b0, r_x} < size_use) && ({1'b0, r_y} < size_use)
                    && ({1'b0, r_z} < size_use);

    // Form the current neighbour probe; wrap below zero lands out of range
    assign nx       = {1'b0, r_x} + cand_dx(r_k);
    assign nz       = {1'b0, r_z} + cand_dz(r_k);
    assign ny       = r_y - COORD_W'(1);
    assign cand_out = (nx >= size_use) || (nz >= size_use);

    assign src_row  = {r_x, r_y};
    assign cand_row = {nx[COORD_W-1:0], ny};
    assign bit_z    = ROW_W'(1) << r_z;
    assign bit_nz   = ROW_W'(1) << nz[COORD_W-1:0];

    // Evaluate the jump condition
    always_comb begin
        unique case (u.cond)
            C_BAD:        cond_true = (r_cmd == CMD_NONE)
                                   || ((r_cmd != CMD_CLEAR) && !in_grid);
            C_CLEAR:      cond_true = (r_cmd == CMD_CLEAR);
            C_ADD:        cond_true = (r_cmd == CMD_ADD);
            C_SRC_EMPTY:  cond_true = !r_rdata[r_z];
            C_SRC_SET:    cond_true = r_rdata[r_z];
            C_FLOOR:      cond_true = (r_y == '0);
            C_CAND_FREE:  cond_true = !r_rdata[nz[COORD_W-1:0]];
            C_K_LAST:     cond_true = (r_k == K_LAST);
            C_CAND_OUT:   cond_true = cand_out;
            C_SWEEP_MORE: cond_true = (r_sweep != '1);
            default:      cond_true = 1'b0;
        endcase
    end

    // Select the next step
    always_comb begin
        n_pc = r_pc;
        if (go) begin
            unique case (u.jmp)
                J_SEQ:   n_pc = r_pc + t_pc'(1);
                J_ALW:   n_pc = u.target;
                J_IF:    n_pc = cond_true ? u.target : r_pc + t_pc'(1);
                default: n_pc = PC_IDLE;
            endcase
        end
    end

    // Select memory addresses and write data
    assign raddr = (u.asel == A_CAND) ? cand_row : src_row;

    always_comb begin
        unique case (u.wsel)
            W_CAND_SET: begin
                waddr = cand_row;
                wdata = r_rdata | bit_nz;
            end
            W_SRC_SET: begin
                waddr = src_row;
                wdata = r_rdata | bit_z;
            end
            W_SRC_CLR: begin
                waddr = src_row;
                wdata = r_src_row & ~bit_z;
            end
            W_ZERO: begin
                waddr = r_sweep;
                wdata = '0;
            end
            default: begin
                waddr = r_sweep;
                wdata = '0;
            end
        endcase
    end

    // Access the occupancy memory
    always_ff @(posedge i_clk) begin
        if (u.wr) begin
            mem[waddr] <= wdata;
        end
        if (u.rd) begin
            r_rdata <= mem[raddr];
        end
    end

    // Advance sequencer, counters and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= PC_RST_SWEEP;
            r_k         <= '0;
            r_sweep     <= '0;
            r_count     <= '0;
            r_grid_size <= SIZE_W'(32);
            r_out_valid <= 1'b0;
        end else begin
            r_pc <= n_pc;
            if (i_cfg_we) begin
                r_grid_size <= i_cfg_wdata;
            end
            if (u.k_clr) begin
                r_k <= '0;
            end else if (u.k_inc) begin
                r_k <= r_k + K_W'(1);
            end
            if (u.sweep) begin
                r_sweep <= r_sweep + ROW_AW'(1);
            end
            if (u.cnt_clr) begin
                r_count <= '0;
            end else if (u.cnt_inc && (r_count != '1)) begin
                r_count <= r_count + CNT_W'(1);
            end
            if (u.emit && go) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Hold command, grain position and result payload
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cmd <= i_cmd;
            r_x   <= i_in_x;
            r_y   <= i_in_y;
            r_z   <= i_in_z;
        end else if (u.pos_clr) begin
            r_x <= '0;
            r_y <= '0;
            r_z <= '0;
        end else if (u.pos_upd) begin
            r_x <= nx[COORD_W-1:0];
            r_y <= ny;
            r_z <= nz[COORD_W-1:0];
        end
        if (u.src_cap) begin
            r_src_row <= r_rdata;
        end
        if (u.emit && go) begin
            r_status <= u.status;
            r_ox     <= r_x;
            r_oy     <= r_y;
            r_oz     <= r_z;
            r_ototal <= r_count;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_out_x       = r_ox;
    assign o_out_y       = r_oy;
    assign o_out_z       = r_oz;
    assign o_grain_total = r_ototal;

    // Checks on the sequencer and memory port
    `ASSERT_ALWAYS(a_port_single, i_clk, i_rst_n, !(u.rd && u.wr))
    `ASSERT_ALWAYS(a_probe_inside, i_clk, i_rst_n, !(u.rd && (u.asel == A_CAND) && cand_out))
    `ASSERT_NEXT(a_accept_starts, i_clk, i_rst_n, in_acc, r_pc == PC_CHK_BAD)

endmodule
